/* sv/sscm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscm_pkg
// Shared types, widths and command codes of the subband centre mixer.
// ----------------------------------------------------------------------------
package sscm_pkg;

    localparam int DEF_NUM_BANDS = 5;
    localparam int SAMPLE_BITS   = 24;
    localparam int SB            = SAMPLE_BITS;
    localparam int DOWN_SHIFT    = (SB > 24) ? SB - 24 : 0;
    localparam int UP_SHIFT      = (SB < 24) ? 24 - SB : 0;
    localparam int MAGW          = 25;
    localparam int PWRW          = 48;
    localparam int HALF          = 24;
    localparam int AW            = (SB + 2 > 26) ? SB + 2 : 26;
    localparam int BW            = 26;
    localparam int PW            = AW + BW;
    localparam int ACW           = (PW + 2 > 68) ? PW + 2 : 68;
    localparam int EMA_SHIFT     = 16;
    localparam int CTR_SHIFT     = 16;
    localparam int MIX_SHIFT     = 15;
    localparam int QW            = 33;
    localparam int REMW          = PWRW + 2;
    localparam int RTW           = 34;
    localparam int SW            = 17;
    localparam int DIV_STEPS     = 32;
    localparam int ROOT_STEPS    = 17;
    localparam int ALPHA_REGS    = 5;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int STEP_W        = 5;

    localparam logic [CFG_IDX_W-1:0] REG_SIDE_MIX = CFG_IDX_W'(ALPHA_REGS);
    localparam logic [15:0] ALPHA_RESET = 16'd4096;
    localparam logic [15:0] MIX_RESET   = 16'd16384;
    localparam logic [PWRW-1:0] SUM_FLOOR = PWRW'(64'd8388608);

    typedef struct packed {
        logic [2:0]             band;
        logic                   band_active;
        logic signed [SB-1:0]   left_in;
        logic signed [SB-1:0]   right_in;
    } sample_t;

    typedef struct packed {
        logic [2:0]             band_out;
        logic signed [SB-1:0]   left_out;
        logic signed [SB-1:0]   right_out;
    } result_t;

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_PWR_S,
        CMD_PWR_D,
        CMD_ES0,
        CMD_ES1,
        CMD_ES2,
        CMD_ES3,
        CMD_ED0,
        CMD_ED1,
        CMD_ED2,
        CMD_ED3,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_ROOT_INIT,
        CMD_ROOT_STEP,
        CMD_CENTRE,
        CMD_ML0,
        CMD_ML1,
        CMD_MR0,
        CMD_MR1,
        CMD_WRITE
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic item_proc;
        logic out_free;
    } dp_status_t;

endpackage

/* sv/subband_stereo_centre_mixer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subband_stereo_centre_mixer
// Per-band centre extraction and stereo remix of subband sample pairs.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel: one beat per subband left/right pair with band number and
//   active flag. result channel: one beat per sample beat, in order. cfg
//   channel: index 0..4 alpha of bands 0..4, index 5 side mix; always ready.
//   Write it only while the block is idle; the block does not enforce it.
// Sequence:
//   An active in-range beat passes from acceptance to the result register
//   through 12 multiply/average steps on one shared multiplier, 32 steps
//   of the restoring divider, 18 of the square-root unit, 7 mixing steps and
//   a write. A pass-through beat goes straight to the write. One beat is in
//   work at a time; the next is accepted once the current one reaches the
//   output.
// Reset:
//   Band averages clear to zero, alphas to 4096, side mix to 16384.
// Stall:
//   The output register holds a result until taken; a finished item waits
//   in the datapath for a free output slot without losing state.
// ----------------------------------------------------------------------------
module subband_stereo_centre_mixer #(
    parameter int NUM_BANDS = sscm_pkg::DEF_NUM_BANDS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_ready,
    input  sscm_pkg::sample_t                 sample,
    output logic                              result_valid,
    input  logic                              result_ready,
    output sscm_pkg::result_t                 result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sscm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sscm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sscm_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    sscm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .status       (status),
        .cmd          (cmd)
    );

    sscm_datapath #(
        .NUM_BANDS (NUM_BANDS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

/* sv/sscm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscm_ctrl
// Sequencer: steps the datapath through power, averaging, divide, root, mix.
// ----------------------------------------------------------------------------
module sscm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  sscm_pkg::dp_status_t status,
    output sscm_pkg::ctrl_cmd_t  cmd
);
    import sscm_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PRE   = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_ROOT  = 3'd3;
    localparam logic [2:0] S_MIX   = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;

    localparam logic [STEP_W-1:0] PRE_LAST  = STEP_W'(11);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_STEPS - 1);
    localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_STEPS);
    localparam logic [STEP_W-1:0] MIX_LAST  = STEP_W'(6);

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    assign sample_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg + STEP_W'(1);
        cmd.op     = CMD_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                step_next = '0;
                if (sample_valid)
                begin
                    cmd.op     = CMD_LOAD;
                    state_next = status.item_proc ? S_PRE : S_WRITE;
                end
            end
            S_PRE:
            begin
                unique case (step_reg)
                    5'd0:    cmd.op = CMD_PWR_S;
                    5'd1:    cmd.op = CMD_PWR_D;
                    5'd2:    cmd.op = CMD_ES0;
                    5'd3:    cmd.op = CMD_ES1;
                    5'd4:    cmd.op = CMD_ES2;
                    5'd5:    cmd.op = CMD_ES3;
                    5'd6:    cmd.op = CMD_ED0;
                    5'd7:    cmd.op = CMD_ED1;
                    5'd8:    cmd.op = CMD_ED2;
                    5'd9:    cmd.op = CMD_ED3;
                    5'd11:   cmd.op = CMD_DIV_INIT;
                    default: cmd.op = CMD_NOP;
                endcase
                if (step_reg == PRE_LAST)
                begin
                    state_next = S_DIV;
                    step_next  = '0;
                end
            end
            S_DIV:
            begin
                cmd.op = CMD_DIV_STEP;
                if (step_reg == DIV_LAST)
                begin
                    state_next = S_ROOT;
                    step_next  = '0;
                end
            end
            S_ROOT:
            begin
                cmd.op = (step_reg == '0) ? CMD_ROOT_INIT : CMD_ROOT_STEP;
                if (step_reg == ROOT_LAST)
                begin
                    state_next = S_MIX;
                    step_next  = '0;
                end
            end
            S_MIX:
            begin
                unique case (step_reg)
                    5'd0:    cmd.op = CMD_CENTRE;
                    5'd2:    cmd.op = CMD_ML0;
                    5'd3:    cmd.op = CMD_ML1;
                    5'd4:    cmd.op = CMD_MR0;
                    5'd5:    cmd.op = CMD_MR1;
                    default: cmd.op = CMD_NOP;
                endcase
                if (step_reg == MIX_LAST)
                begin
                    state_next = S_WRITE;
                    step_next  = '0;
                end
            end
            S_WRITE:
            begin
                step_next = '0;
                if (status.out_free)
                begin
                    cmd.op     = CMD_WRITE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                step_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> !sample_ready)
        else $error("ready held after a beat was taken");

    a_write_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE && !status.out_free) |=> (state_reg == S_WRITE))
        else $error("left write state with output slot full");

    a_idle_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (cmd.op == CMD_LOAD || cmd.op == CMD_NOP))
        else $error("datapath command issued while idle");

endmodule

/* sv/sscm_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscm_datapath
// Registers, shared multiplier, divider and root steps, band averages.
// ----------------------------------------------------------------------------
module sscm_datapath #(
    parameter int NUM_BANDS = sscm_pkg::DEF_NUM_BANDS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sscm_pkg::sample_t                 sample,
    output sscm_pkg::result_t                 result,
    output logic                              result_valid,
    input  logic                              result_ready,
    input  logic                              cfg_valid,
    input  logic [sscm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sscm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  sscm_pkg::ctrl_cmd_t               cmd,
    output sscm_pkg::dp_status_t              status
);
    import sscm_pkg::*;

    localparam int IW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB - 1){1'b1}}};
    localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB - 1){1'b0}}};
    localparam int MWW = SB + 1 + UP_SHIFT;

    function automatic logic signed [SB-1:0] sat_sample(input logic signed [ACW-1:0] v);
        logic signed [SB-1:0] r;
        if (v > ACW'(S_MAX))
            r = S_MAX;
        else if (v < ACW'(S_MIN))
            r = S_MIN;
        else
            r = v[SB-1:0];
        return r;
    endfunction

    function automatic logic [MAGW-1:0] scaled_mag(input logic signed [SB:0] v);
        logic [SB:0]    a;
        logic [MWW-1:0] w;
        a = v[SB] ? (SB + 1)'(0) - v : v;
        w = (MWW'(a) >> DOWN_SHIFT) << UP_SHIFT;
        return MAGW'(w);
    endfunction

    // configuration
    logic [15:0] alpha_reg [ALPHA_REGS];
    logic [15:0] mix_reg;

    // band averages
    logic [PWRW-1:0] sum_avg_reg  [NUM_BANDS];
    logic [PWRW-1:0] diff_avg_reg [NUM_BANDS];

    // item registers
    logic [2:0]            band_reg;
    logic [IW-1:0]         idx_reg;
    logic                  proc_reg;
    logic signed [SB-1:0]  left_reg, right_reg;
    logic signed [SB:0]    sum_reg;
    logic [MAGW-1:0]       mag_s_reg, mag_d_reg;
    logic [15:0]           a_reg;
    logic [PWRW-1:0]       old_s_reg, old_d_reg;
    logic [PWRW-1:0]       ssq_reg, dsq_reg, sum_new_reg;
    logic signed [PW-1:0]  prod_reg;
    cmd_op_t               pend_reg;
    logic signed [ACW-1:0] acc_reg;
    logic                  div_sat_reg;
    logic [REMW-1:0]       rem_reg, den4_reg;
    logic [QW-1:0]         q_reg;
    logic [QW-1:0]         rt_r_reg;
    logic [RTW-1:0]        rt_res_reg, rt_bit_reg;
    logic signed [SB:0]    centre_reg;
    logic signed [SB-1:0]  left_res_reg;
    result_t               out_reg;
    logic                  out_valid_reg;

    logic [3:0]            band_ext;
    logic [IW-1:0]         in_idx;
    logic signed [SB:0]    in_sum, in_diff;
    logic [16:0]           w_val;
    logic signed [17:0]    f_val, cm_val;
    logic signed [SB+1:0]  dl, dr;
    logic signed [AW-1:0]  a_op;
    logic signed [BW-1:0]  b_op;
    logic signed [ACW-1:0] prod_ext, acc_shr;
    logic [PWRW-1:0]       diff_new, pwr_sat;
    logic                  small_sum;
    logic [REMW:0]         rem2;
    logic [RTW-1:0]        rt_try;

    assign band_ext  = {1'b0, sample.band};
    assign in_idx    = band_ext[IW-1:0];
    assign in_sum    = (SB + 1)'(sample.left_in) + (SB + 1)'(sample.right_in);
    assign in_diff   = (SB + 1)'(sample.left_in) - (SB + 1)'(sample.right_in);
    assign w_val     = 17'd65536 - {1'b0, a_reg};
    assign f_val     = $signed(18'd32768) - $signed({1'b0, rt_res_reg[SW-1:0]});
    assign cm_val    = $signed(18'd32768) - $signed({2'b00, mix_reg});
    assign dl        = (SB + 2)'(left_reg) - (SB + 2)'(centre_reg);
    assign dr        = (SB + 2)'(right_reg) - (SB + 2)'(centre_reg);
    assign prod_ext  = ACW'(prod_reg);
    assign acc_shr   = acc_reg >>> MIX_SHIFT;
    assign diff_new  = acc_reg[EMA_SHIFT +: PWRW];
    assign pwr_sat   = (prod_reg[PW-1:PWRW] != '0) ? {PWRW{1'b1}} : prod_reg[PWRW-1:0];
    assign small_sum = (ssq_reg <= SUM_FLOOR);
    assign rem2      = {rem_reg, 1'b0};
    assign rt_try    = rt_res_reg + rt_bit_reg;

    assign status.item_proc = sample.band_active && (32'(sample.band) < NUM_BANDS);
    assign status.out_free  = !out_valid_reg || result_ready;
    assign result           = out_reg;
    assign result_valid     = out_valid_reg;

    always_comb
    begin
        a_op = '0;
        b_op = '0;
        unique case (cmd.op)
            CMD_PWR_S:
            begin
                a_op = AW'($signed({1'b0, mag_s_reg}));
                b_op = BW'($signed({1'b0, mag_s_reg}));
            end
            CMD_PWR_D:
            begin
                a_op = AW'($signed({1'b0, mag_d_reg}));
                b_op = BW'($signed({1'b0, mag_d_reg}));
            end
            CMD_ES0:
            begin
                a_op = AW'($signed({1'b0, old_s_reg[HALF-1:0]}));
                b_op = BW'($signed({1'b0, w_val}));
            end
            CMD_ES1:
            begin
                a_op = AW'($signed({1'b0, old_s_reg[PWRW-1:HALF]}));
                b_op = BW'($signed({1'b0, w_val}));
            end
            CMD_ES2:
            begin
                a_op = AW'($signed({1'b0, ssq_reg[HALF-1:0]}));
                b_op = BW'($signed({1'b0, a_reg}));
            end
            CMD_ES3:
            begin
                a_op = AW'($signed({1'b0, ssq_reg[PWRW-1:HALF]}));
                b_op = BW'($signed({1'b0, a_reg}));
            end
            CMD_ED0:
            begin
                a_op = AW'($signed({1'b0, old_d_reg[HALF-1:0]}));
                b_op = BW'($signed({1'b0, w_val}));
            end
            CMD_ED1:
            begin
                a_op = AW'($signed({1'b0, old_d_reg[PWRW-1:HALF]}));
                b_op = BW'($signed({1'b0, w_val}));
            end
            CMD_ED2:
            begin
                a_op = AW'($signed({1'b0, dsq_reg[HALF-1:0]}));
                b_op = BW'($signed({1'b0, a_reg}));
            end
            CMD_ED3:
            begin
                a_op = AW'($signed({1'b0, dsq_reg[PWRW-1:HALF]}));
                b_op = BW'($signed({1'b0, a_reg}));
            end
            CMD_CENTRE:
            begin
                a_op = AW'(sum_reg);
                b_op = BW'(f_val);
            end
            CMD_ML0:
            begin
                a_op = AW'(dl);
                b_op = BW'($signed({1'b0, mix_reg}));
            end
            CMD_MR0:
            begin
                a_op = AW'(dr);
                b_op = BW'($signed({1'b0, mix_reg}));
            end
            CMD_ML1, CMD_MR1:
            begin
                a_op = AW'(centre_reg);
                b_op = BW'(cm_val);
            end
            default:
            begin
                a_op = '0;
                b_op = '0;
            end
        endcase
    end

    // control, configuration and band state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ALPHA_REGS; i++)
                alpha_reg[i] <= ALPHA_RESET;
            mix_reg <= MIX_RESET;
            for (int i = 0; i < NUM_BANDS; i++)
            begin
                sum_avg_reg[i]  <= '0;
                diff_avg_reg[i] <= '0;
            end
            pend_reg      <= CMD_NOP;
            out_valid_reg <= 1'b0;
            div_sat_reg   <= 1'b1;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index < REG_SIDE_MIX)
                    alpha_reg[cfg_index] <= cfg_data;
                else if (cfg_index == REG_SIDE_MIX)
                    mix_reg <= cfg_data;
            end
            pend_reg <= cmd.op;
            if (cmd.op == CMD_DIV_INIT)
            begin
                sum_avg_reg[idx_reg]  <= sum_new_reg;
                diff_avg_reg[idx_reg] <= diff_new;
                div_sat_reg <= (sum_new_reg == '0) ||
                               ({2'b00, diff_new} >= {sum_new_reg, 2'b00});
            end
            if (cmd.op == CMD_WRITE)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        prod_reg <= a_op * b_op;

        unique case (cmd.op)
            CMD_LOAD:
            begin
                band_reg  <= sample.band;
                idx_reg   <= in_idx;
                proc_reg  <= status.item_proc;
                left_reg  <= sample.left_in;
                right_reg <= sample.right_in;
                sum_reg   <= in_sum;
                mag_s_reg <= scaled_mag(in_sum);
                mag_d_reg <= scaled_mag(in_diff);
                a_reg     <= (sample.band < 3'(ALPHA_REGS)) ? alpha_reg[sample.band]
                                                            : alpha_reg[ALPHA_REGS - 1];
                old_s_reg <= sum_avg_reg[in_idx];
                old_d_reg <= diff_avg_reg[in_idx];
            end
            CMD_DIV_INIT:
            begin
                rem_reg  <= REMW'(diff_new);
                den4_reg <= {sum_new_reg, 2'b00};
                q_reg    <= ((sum_new_reg == '0) ||
                             ({2'b00, diff_new} >= {sum_new_reg, 2'b00}))
                            ? QW'(64'd4294967296) : '0;
            end
            CMD_DIV_STEP:
            begin
                if (!div_sat_reg)
                begin
                    if (rem2 >= {1'b0, den4_reg})
                    begin
                        rem_reg <= REMW'(rem2 - {1'b0, den4_reg});
                        q_reg   <= {q_reg[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem2[REMW-1:0];
                        q_reg   <= {q_reg[QW-2:0], 1'b0};
                    end
                end
            end
            CMD_ROOT_INIT:
            begin
                rt_r_reg   <= q_reg;
                rt_res_reg <= '0;
                rt_bit_reg <= RTW'(64'd4294967296);
            end
            CMD_ROOT_STEP:
            begin
                if (RTW'(rt_r_reg) >= rt_try)
                begin
                    rt_r_reg   <= QW'(RTW'(rt_r_reg) - rt_try);
                    rt_res_reg <= (rt_res_reg >> 1) + rt_bit_reg;
                end
                else
                begin
                    rt_res_reg <= rt_res_reg >> 1;
                end
                rt_bit_reg <= rt_bit_reg >> 2;
            end
            CMD_WRITE:
            begin
                out_reg.band_out  <= band_reg;
                out_reg.left_out  <= proc_reg ? left_res_reg : left_reg;
                out_reg.right_out <= proc_reg ? sat_sample(acc_shr) : right_reg;
            end
            default:
            begin
            end
        endcase

        // product post-processing, in the cycle after the multiply
        unique case (pend_reg)
            CMD_PWR_S: ssq_reg <= pwr_sat;
            CMD_PWR_D: dsq_reg <= pwr_sat;
            CMD_ES0, CMD_ML0:
                acc_reg <= prod_ext;
            CMD_ED0:
            begin
                sum_new_reg <= acc_reg[EMA_SHIFT +: PWRW];
                acc_reg     <= prod_ext;
            end
            CMD_MR0:
            begin
                left_res_reg <= sat_sample(acc_shr);
                acc_reg      <= prod_ext;
            end
            CMD_ES1, CMD_ES3, CMD_ED1, CMD_ED3:
                acc_reg <= acc_reg + (prod_ext <<< HALF);
            CMD_ES2, CMD_ED2, CMD_ML1, CMD_MR1:
                acc_reg <= acc_reg + prod_ext;
            CMD_CENTRE:
                centre_reg <= small_sum ? '0 : (SB + 1)'(prod_ext >>> CTR_SHIFT);
            default:
            begin
            end
        endcase
    end

    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == CMD_WRITE) |-> status.out_free)
        else $error("result written over a waiting beat");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !div_sat_reg |-> (rem_reg < den4_reg))
        else $error("divider remainder out of range");

    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == CMD_CENTRE) |-> (rt_res_reg <= RTW'(65536)))
        else $error("root above unity");

endmodule
